FILE: hw/rtl/dwms_pkg.sv
// Shared constants, codes and control types for the decayed window statistics block.
package dwms_pkg;

	// Window storage
	localparam int WINDOW_DEPTH = 64;
	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);

	// Field widths
	localparam int BIAS_W = 16;
	localparam int CONF_W = 16;
	localparam int WLEN_W = 7;
	localparam int DECAY_W = 17;
	localparam int CFG_W = 17;
	localparam int CFG_IDX_W = 1;
	localparam int CMD_W = 2;
	localparam logic [DECAY_W-1:0] DECAY_ONE = DECAY_W'(65536);

	// Accumulator and arithmetic widths
	localparam int SUM_W = BIAS_W + AW + 1;
	localparam int MAG_W = SUM_W - 1;
	localparam int CSUM_W = CONF_W + AW;
	localparam int SQ_W = 2 * BIAS_W - 1;
	localparam int S2_W = SQ_W + AW;
	localparam int PROD_W = 2 * MAG_W;
	localparam int DIV_W = PROD_W;
	localparam int DEN_W = $clog2(WINDOW_DEPTH * (WINDOW_DEPTH - 1) + 1);
	localparam int SQRT_STEPS = PROD_W / 2;
	localparam int STEP_W = $clog2(DIV_W + 1);

	// Commands carried in tuser
	localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SUMMARY = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DECAY_FACTOR = 1'd1;

	// Divider operand selection
	localparam logic [1:0] DIV_MEAN = 2'd0;
	localparam logic [1:0] DIV_CMEAN = 2'd1;
	localparam logic [1:0] DIV_VAR = 2'd2;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic clear;
		logic rd_en;
		logic [AW-1:0] rd_off;
		logic decay_mode;
		logic acc_clear;
		logic append;
		logic mul;
		logic num;
		logic div_load;
		logic div_step;
		logic div_store;
		logic [1:0] div_sel;
		logic sqrt_load;
		logic sqrt_step;
		logic finish;
	} dwms_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic [CNT_W-1:0] fill;
		logic out_free;
	} dwms_stat_t;

endpackage

FILE: hw/rtl/dwms_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dwms_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/dwms_datapath.sv
// Datapath: window storage, accumulators, shared divider, square root and result register.
module dwms_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  dwms_pkg::dwms_cmd_t            cmd,
	output dwms_pkg::dwms_stat_t           stat,
	input  logic                           cfg_we,
	input  logic [dwms_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dwms_pkg::CFG_W-1:0]     cfg_data,
	input  logic [31:0]                    s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [55:0]                    m_tdata
);

	localparam int AW = dwms_pkg::AW;
	localparam int CNT_W = dwms_pkg::CNT_W;
	localparam int DEPTH = dwms_pkg::WINDOW_DEPTH;

	// Configuration and ring state
	logic [dwms_pkg::WLEN_W-1:0]  wlen_q;
	logic [dwms_pkg::DECAY_W-1:0] decay_q;
	logic [AW-1:0]                oldest_q;
	logic [CNT_W-1:0]             fill_q;
	logic signed [15:0]           bias_in_q;
	logic [15:0]                  conf_in_q;

	// Storage ports
	logic          bias_we;
	logic [AW-1:0] bias_waddr;
	logic [15:0]   bias_wdata;
	logic [AW-1:0] rd_addr;
	logic [15:0]   bias_rd;
	logic [15:0]   conf_rd;

	// Walk pipeline
	logic          valid_s1;
	logic          decay_s1;
	logic [AW-1:0] addr_s1;
	logic          valid_s2;
	logic signed [15:0]         b_s2;
	logic [15:0]                c_s2;
	logic [dwms_pkg::SQ_W-1:0]  sq_s2;

	// Accumulators and products
	logic signed [dwms_pkg::SUM_W-1:0] s1_q;
	logic [dwms_pkg::S2_W-1:0]         s2_q;
	logic [dwms_pkg::CSUM_W-1:0]       cs_q;
	logic [dwms_pkg::MAG_W-1:0]        mag;
	logic [dwms_pkg::PROD_W-1:0]       prod_a_q;
	logic [dwms_pkg::PROD_W-1:0]       prod_b_q;
	logic [dwms_pkg::PROD_W-1:0]       num_q;
	logic [dwms_pkg::DEN_W-1:0]        den_q;

	// Divider and root
	logic [dwms_pkg::DEN_W-1:0] rem_q;
	logic [dwms_pkg::DEN_W-1:0] dvsr_q;
	logic [dwms_pkg::DIV_W-1:0] quo_q;
	logic [dwms_pkg::DEN_W:0]   shifted;
	logic                       ge;
	logic [15:0]                mean_q;
	logic [15:0]                cmean_q;
	logic [dwms_pkg::DIV_W-1:0] var_q;
	logic [dwms_pkg::PROD_W-1:0] sv_q;
	logic [dwms_pkg::PROD_W-1:0] sr_q;
	logic [dwms_pkg::PROD_W-1:0] sbit_q;
	logic [dwms_pkg::PROD_W-1:0] strial;

	// Derived values
	logic [CNT_W-1:0]             eff_len;
	logic [dwms_pkg::DECAY_W-1:0] d_eff;
	logic signed [33:0]           dprod;
	logic                         evict;
	logic [AW-1:0]                oldest_next;
	logic [CNT_W-1:0]             fill_tmp;
	logic [AW-1:0]                app_addr;
	logic                         out_valid_q;
	logic [55:0]                  out_data_q;
	logic [15:0]                  spread;

	// Ring position of an offset from a base slot.
	function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] base,
			input logic [CNT_W-1:0] off);
		logic [AW+1:0] s;
		s = (AW+2)'(base) + (AW+2)'(off);
		if (s >= (AW+2)'(DEPTH)) begin
			s = s - (AW+2)'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	// Effective window length and decay factor.
	always_comb begin
		if (wlen_q == '0) begin
			eff_len = CNT_W'(1);
		end else if (32'(wlen_q) > 32'(DEPTH)) begin
			eff_len = CNT_W'(DEPTH);
		end else begin
			eff_len = CNT_W'(wlen_q);
		end
		d_eff = (decay_q > dwms_pkg::DECAY_ONE) ? dwms_pkg::DECAY_ONE : decay_q;
	end

	// Append position after the optional eviction.
	always_comb begin
		evict = fill_q >= eff_len;
		oldest_next = evict ? slot_add(oldest_q, CNT_W'(1)) : oldest_q;
		fill_tmp = evict ? fill_q - CNT_W'(1) : fill_q;
		app_addr = slot_add(oldest_next, fill_tmp);
	end

	// Decayed bias: floor of the product, an arithmetic shift.
	assign dprod = $signed(bias_rd) * $signed({1'b0, d_eff});

	assign rd_addr = slot_add(oldest_q, CNT_W'(cmd.rd_off));

	always_comb begin
		if (cmd.append) begin
			bias_we = 1'b1;
			bias_waddr = app_addr;
			bias_wdata = bias_in_q;
		end else begin
			bias_we = valid_s1 & decay_s1;
			bias_waddr = addr_s1;
			bias_wdata = dprod[31:16];
		end
	end

	dwms_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_bias_ram (
		.clk   (clk),
		.we    (bias_we),
		.waddr (bias_waddr),
		.wdata (bias_wdata),
		.raddr (rd_addr),
		.rdata (bias_rd)
	);

	dwms_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_conf_ram (
		.clk   (clk),
		.we    (cmd.append),
		.waddr (app_addr),
		.wdata (conf_in_q),
		.raddr (rd_addr),
		.rdata (conf_rd)
	);

	// Configuration writes, ring pointers and walk pipeline control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= dwms_pkg::WLEN_W'(64);
			decay_q <= dwms_pkg::DECAY_ONE;
			oldest_q <= '0;
			fill_q <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					dwms_pkg::CFG_WINDOW_LENGTH: wlen_q <= cfg_data[dwms_pkg::WLEN_W-1:0];
					dwms_pkg::CFG_DECAY_FACTOR: decay_q <= cfg_data[dwms_pkg::DECAY_W-1:0];
					default: ;
				endcase
			end
			if (cmd.clear) begin
				oldest_q <= '0;
				fill_q <= '0;
			end else if (cmd.append) begin
				oldest_q <= oldest_next;
				fill_q <= fill_tmp + CNT_W'(1);
			end
			valid_s1 <= cmd.rd_en;
			valid_s2 <= valid_s1 & ~decay_s1;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers of the datapath.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			bias_in_q <= s_tdata[15:0];
			conf_in_q <= s_tdata[31:16];
		end
		decay_s1 <= cmd.decay_mode;
		addr_s1 <= rd_addr;
		b_s2 <= bias_rd;
		c_s2 <= conf_rd;
		sq_s2 <= dwms_pkg::SQ_W'($signed(bias_rd) * $signed(bias_rd));
		if (cmd.acc_clear) begin
			s1_q <= '0;
			s2_q <= '0;
			cs_q <= '0;
		end else if (valid_s2) begin
			s1_q <= s1_q + dwms_pkg::SUM_W'(b_s2);
			s2_q <= s2_q + dwms_pkg::S2_W'(sq_s2);
			cs_q <= cs_q + dwms_pkg::CSUM_W'(c_s2);
		end
		if (cmd.mul) begin
			prod_a_q <= dwms_pkg::PROD_W'(fill_q) * dwms_pkg::PROD_W'(s2_q);
			prod_b_q <= dwms_pkg::PROD_W'(mag) * dwms_pkg::PROD_W'(mag);
		end
		if (cmd.num) begin
			num_q <= prod_a_q - prod_b_q;
			den_q <= dwms_pkg::DEN_W'(fill_q) * dwms_pkg::DEN_W'(fill_q - CNT_W'(1));
		end
		// Restoring divider, one quotient bit a cycle.
		if (cmd.div_load) begin
			rem_q <= '0;
			case (cmd.div_sel)
				dwms_pkg::DIV_MEAN: quo_q <= dwms_pkg::DIV_W'(mag);
				dwms_pkg::DIV_CMEAN: quo_q <= dwms_pkg::DIV_W'(cs_q);
				default: quo_q <= num_q;
			endcase
			dvsr_q <= (cmd.div_sel == dwms_pkg::DIV_VAR) ? den_q : dwms_pkg::DEN_W'(fill_q);
		end else if (cmd.div_step) begin
			rem_q <= ge ? dwms_pkg::DEN_W'(shifted - {1'b0, dvsr_q}) : shifted[dwms_pkg::DEN_W-1:0];
			quo_q <= {quo_q[dwms_pkg::DIV_W-2:0], ge};
		end
		if (cmd.div_store) begin
			case (cmd.div_sel)
				dwms_pkg::DIV_MEAN: mean_q <= s1_q[dwms_pkg::SUM_W-1] ? -quo_q[15:0] : quo_q[15:0];
				dwms_pkg::DIV_CMEAN: cmean_q <= quo_q[15:0];
				default: var_q <= quo_q;
			endcase
		end
		// Integer square root, one result bit a cycle.
		if (cmd.sqrt_load) begin
			sv_q <= var_q;
			sr_q <= '0;
			sbit_q <= dwms_pkg::PROD_W'(1) << (dwms_pkg::PROD_W - 2);
		end else if (cmd.sqrt_step) begin
			if (sv_q >= strial) begin
				sv_q <= sv_q - strial;
				sr_q <= (sr_q >> 1) + sbit_q;
			end else begin
				sr_q <= sr_q >> 1;
			end
			sbit_q <= sbit_q >> 2;
		end
		if (cmd.finish) begin
			if (fill_q == '0) begin
				out_data_q <= '0;
			end else begin
				out_data_q <= {evict, 7'(fill_q), spread, cmean_q, mean_q};
			end
		end
	end

	// Magnitude of the bias sum, divider trial and root trial.
	always_comb begin
		mag = s1_q[dwms_pkg::SUM_W-1] ? dwms_pkg::MAG_W'(-s1_q) : dwms_pkg::MAG_W'(s1_q);
		shifted = {rem_q, quo_q[dwms_pkg::DIV_W-1]};
		ge = shifted >= {1'b0, dvsr_q};
		strial = sr_q + sbit_q;
		if (fill_q < CNT_W'(2)) begin
			spread = '0;
		end else if (sr_q > dwms_pkg::PROD_W'(16'hFFFF)) begin
			spread = 16'hFFFF;
		end else begin
			spread = sr_q[15:0];
		end
	end

	assign stat.fill = fill_q;
	assign stat.out_free = ~out_valid_q | m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

endmodule

FILE: hw/rtl/dwms_ctrl.sv
// Controller: sequences the window walks, the divisions and the square root.
module dwms_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [dwms_pkg::CMD_W-1:0] s_tuser,
	input  dwms_pkg::dwms_stat_t       stat,
	output dwms_pkg::dwms_cmd_t        cmd
);

	localparam int CNT_W = dwms_pkg::CNT_W;
	localparam int STEP_W = dwms_pkg::STEP_W;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DECAY = 4'd1;
	localparam logic [3:0] ST_DECAY_DRAIN = 4'd2;
	localparam logic [3:0] ST_APPEND = 4'd3;
	localparam logic [3:0] ST_SUM = 4'd4;
	localparam logic [3:0] ST_SUM_DRAIN = 4'd5;
	localparam logic [3:0] ST_MUL = 4'd6;
	localparam logic [3:0] ST_NUM = 4'd7;
	localparam logic [3:0] ST_DIV_LOAD = 4'd8;
	localparam logic [3:0] ST_DIV_RUN = 4'd9;
	localparam logic [3:0] ST_DIV_STORE = 4'd10;
	localparam logic [3:0] ST_SQRT_LOAD = 4'd11;
	localparam logic [3:0] ST_SQRT_RUN = 4'd12;
	localparam logic [3:0] ST_FIN = 4'd13;

	logic [3:0]        state_q;
	logic [3:0]        state_d;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  idx_d;
	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_d;
	logic [1:0]        sel_q;
	logic [1:0]        sel_d;

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		step_d = step_q;
		sel_d = sel_q;
		cmd = '0;
		cmd.rd_off = idx_q[dwms_pkg::AW-1:0];
		cmd.div_sel = sel_q;
		s_tready = 1'b0;
		unique case (state_q) inside
			ST_IDLE: begin
				s_tready = 1'b1;
				idx_d = '0;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					case (s_tuser)
						dwms_pkg::CMD_PUSH: state_d = ST_DECAY;
						dwms_pkg::CMD_SUMMARY: begin
							cmd.acc_clear = 1'b1;
							state_d = ST_SUM;
						end
						dwms_pkg::CMD_CLEAR: cmd.clear = 1'b1;
						default: ;
					endcase
				end
			end
			ST_DECAY, ST_SUM: begin
				cmd.decay_mode = (state_q == ST_DECAY);
				step_d = '0;
				if (idx_q < stat.fill) begin
					cmd.rd_en = 1'b1;
					idx_d = idx_q + CNT_W'(1);
				end else begin
					state_d = (state_q == ST_DECAY) ? ST_DECAY_DRAIN : ST_SUM_DRAIN;
				end
			end
			ST_DECAY_DRAIN, ST_SUM_DRAIN: begin
				step_d = step_q + STEP_W'(1);
				if (step_q == STEP_W'(2)) begin
					state_d = (state_q == ST_DECAY_DRAIN) ? ST_APPEND : ST_MUL;
				end
			end
			ST_APPEND: begin
				cmd.append = 1'b1;
				state_d = ST_IDLE;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_NUM;
			end
			ST_NUM: begin
				cmd.num = 1'b1;
				sel_d = dwms_pkg::DIV_MEAN;
				state_d = ST_DIV_LOAD;
			end
			ST_DIV_LOAD: begin
				cmd.div_load = 1'b1;
				step_d = '0;
				state_d = ST_DIV_RUN;
			end
			ST_DIV_RUN: begin
				cmd.div_step = 1'b1;
				step_d = step_q + STEP_W'(1);
				if (step_q == STEP_W'(dwms_pkg::DIV_W - 1)) begin
					state_d = ST_DIV_STORE;
				end
			end
			ST_DIV_STORE: begin
				cmd.div_store = 1'b1;
				if (sel_q == dwms_pkg::DIV_VAR) begin
					state_d = ST_SQRT_LOAD;
				end else begin
					sel_d = sel_q + 2'd1;
					state_d = ST_DIV_LOAD;
				end
			end
			ST_SQRT_LOAD: begin
				cmd.sqrt_load = 1'b1;
				step_d = '0;
				state_d = ST_SQRT_RUN;
			end
			ST_SQRT_RUN: begin
				cmd.sqrt_step = 1'b1;
				step_d = step_q + STEP_W'(1);
				if (step_q == STEP_W'(dwms_pkg::SQRT_STEPS - 1)) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Controller registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			step_q <= '0;
			sel_q <= dwms_pkg::DIV_MEAN;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
			step_q <= step_d;
			sel_q <= sel_d;
		end
	end

endmodule

FILE: hw/rtl/decayed_window_mean_stddev.sv
// Top level of the decayed sliding-window mean and deviation block.
// One item at a time. In a push every stored bias is read from the bias RAM, aged and
// written back at one entry a cycle, then the new sample is appended. In a summary one
// walk through the RAM accumulates the sums, then a shared bit-serial divider forms the
// two means and the variance one bit a cycle and a bit-serial root finishes the deviation.
// A clear or an unused command is acted on as it is accepted. The result register lets
// the next item enter while a summary still waits at the output. The window RAMs need no
// clearing.
module decayed_window_mean_stddev (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [dwms_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dwms_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [31:0]                    s_tdata,  // bias_in, confidence_in
	input  logic [dwms_pkg::CMD_W-1:0]     s_tuser,  // cmd
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// mean_bias, mean_confidence, bias_spread, sample count, window_full
	output logic [55:0]                    m_tdata
);

	dwms_pkg::dwms_cmd_t  cmd;
	dwms_pkg::dwms_stat_t stat;

	dwms_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.stat     (stat),
		.cmd      (cmd)
	);

	dwms_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

FILE: sim/decayed_window_mean_stddev_tb.sv
// Testbench for the decayed window mean and deviation block, with a scoreboard predictor.
`timescale 1ns / 1ps

// Predicts window statistics and checks returned summaries against them.
class window_stats_board;
	int unsigned errors;
	int bias_mem[64];
	int unsigned conf_mem[64];
	int unsigned head;
	int unsigned count;
	int unsigned win_len;
	int unsigned decay;
	logic [55:0] pending[16];
	int unsigned wr_ptr;
	int unsigned rd_ptr;

	function new();
		errors = 0;
		head = 0;
		count = 0;
		win_len = 64;
		decay = 65536;
		wr_ptr = 0;
		rd_ptr = 0;
	endfunction

	// Number of predicted summaries not yet returned.
	function int unsigned outstanding();
		return wr_ptr - rd_ptr;
	endfunction

	// Mirror a register write.
	function void note_config(logic [dwms_pkg::CFG_IDX_W-1:0] idx, logic [16:0] val);
		if (idx == dwms_pkg::CFG_WINDOW_LENGTH)
			win_len = val[6:0];
		else
			decay = val;
	endfunction

	function int unsigned eff_len();
		if (win_len == 0)
			return 1;
		if (win_len > 64)
			return 64;
		return win_len;
	endfunction

	function longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		for (int k = 31; k >= 0; k--) begin
			b = r | (64'd1 << k);
			if (b * b <= v)
				r = b;
		end
		return r;
	endfunction

	// Advance the window state for one accepted item and queue any summary it causes.
	function void note_item(logic [1:0] cmd, logic signed [15:0] bias, logic [15:0] conf);
		int unsigned d;
		int unsigned s;
		longint p;
		longint s1;
		longint s2;
		longint csum;
		longint mean;
		longint spread;
		longint n;
		logic [55:0] res;
		if (cmd == dwms_pkg::CMD_PUSH) begin
			d = (decay > 65536) ? 65536 : decay;
			for (int i = 0; i < count; i++) begin
				s = (head + i) % 64;
				p = longint'(bias_mem[s]) * longint'(d);
				bias_mem[s] = int'(p >>> 16);
			end
			if (count >= eff_len()) begin
				head = (head + 1) % 64;
				count--;
			end
			s = (head + count) % 64;
			bias_mem[s] = bias;
			conf_mem[s] = conf;
			count++;
		end else if (cmd == dwms_pkg::CMD_CLEAR) begin
			count = 0;
			head = 0;
		end else if (cmd == dwms_pkg::CMD_SUMMARY) begin
			s1 = 0;
			s2 = 0;
			csum = 0;
			mean = 0;
			spread = 0;
			n = count;
			res = '0;
			for (int i = 0; i < count; i++) begin
				s = (head + i) % 64;
				s1 += bias_mem[s];
				s2 += longint'(bias_mem[s]) * bias_mem[s];
				csum += conf_mem[s];
			end
			if (n > 0) begin
				mean = s1 / n;
				res[31:16] = 16'(csum / n);
			end
			if (n >= 2) begin
				spread = int_sqrt((n * s2 - s1 * s1) / (n * (n - 1)));
				if (spread > 65535)
					spread = 65535;
			end
			res[15:0] = mean[15:0];
			res[47:32] = spread[15:0];
			res[54:48] = count[6:0];
			res[55] = (count >= eff_len());
			pending[wr_ptr % 16] = res;
			wr_ptr++;
		end
	endfunction

	// Compare one returned summary with the oldest prediction.
	function void check(logic [55:0] got);
		logic [55:0] exp;
		if (outstanding() == 0) begin
			$error("unexpected summary %h", got);
			errors++;
			return;
		end
		exp = pending[rd_ptr % 16];
		rd_ptr++;
		if (got[15:0] !== exp[15:0]) begin
			$error("mean_bias expected %0d got %0d", $signed(exp[15:0]), $signed(got[15:0]));
			errors++;
		end
		if (got[31:16] !== exp[31:16]) begin
			$error("mean_confidence expected %0d got %0d", exp[31:16], got[31:16]);
			errors++;
		end
		if (got[47:32] !== exp[47:32]) begin
			$error("bias_spread expected %0d got %0d", exp[47:32], got[47:32]);
			errors++;
		end
		if (got[54:48] !== exp[54:48]) begin
			$error("sample_count expected %0d got %0d", exp[54:48], got[54:48]);
			errors++;
		end
		if (got[55] !== exp[55]) begin
			$error("window_full expected %0d got %0d", exp[55], got[55]);
			errors++;
		end
	endfunction
endclass

module decayed_window_mean_stddev_tb;

	// Command code that the block ignores.
	localparam logic [dwms_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [dwms_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [dwms_pkg::CFG_W-1:0] cfg_data;
	logic s_tvalid;
	logic s_tready;
	logic [31:0] s_tdata;
	logic [dwms_pkg::CMD_W-1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [55:0] m_tdata;

	window_stats_board board;
	bit quiet;
	bit hold_req;

	decayed_window_mean_stddev dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Send one item, with an optional random gap before it.
	task automatic send_item(logic [1:0] cmd, logic [15:0] bias, logic [15:0] conf);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {conf, bias};
		do @(posedge clk); while (!s_tready);
		board.note_item(cmd, bias, conf);
	endtask

	// Wait until every predicted summary has come back.
	task automatic wait_drained();
		while (board.outstanding() != 0)
			@(posedge clk);
	endtask

	// Let the block drain completely, then write a register.
	task automatic write_reg(logic [dwms_pkg::CFG_IDX_W-1:0] idx, logic [16:0] val);
		s_tvalid <= 1'b0;
		wait_drained();
		repeat (100) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.note_config(idx, val);
	endtask

	function automatic logic [15:0] pick_bias();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// Mostly pushes and summaries, with rare clears and unused commands.
	task automatic random_items(int num);
		int r;
		logic [1:0] cmd;
		for (int i = 0; i < num; i++) begin
			r = $urandom_range(0, 99);
			if (r < 58)
				cmd = dwms_pkg::CMD_PUSH;
			else if (r < 94)
				cmd = dwms_pkg::CMD_SUMMARY;
			else if (r < 97)
				cmd = dwms_pkg::CMD_CLEAR;
			else
				cmd = CMD_UNUSED;
			send_item(cmd, pick_bias(),
				($urandom_range(0, 4) == 0) ? 16'hFFFF : 16'($urandom));
		end
	endtask

	// Accept summaries as they are returned.
	always @(posedge clk)
		if (m_tvalid && m_tready)
			board.check(m_tdata);

	// Output side readiness, including one long hold-off when asked.
	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (3000) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 30)) @(posedge clk);
			end
		end
	end

	initial begin
		#(12 * 4000000);
		$display("FAILURE");
		$finish;
	end

	initial begin
		board = new();
		quiet = 1'b0;
		hold_req = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty, single entry, extremes, unused command, clear.
		send_item(dwms_pkg::CMD_SUMMARY, 16'h1234, 16'h5678);
		send_item(dwms_pkg::CMD_PUSH, 16'h8000, 16'hFFFF);
		send_item(dwms_pkg::CMD_SUMMARY, 16'h0, 16'h0);
		send_item(dwms_pkg::CMD_PUSH, 16'h7FFF, 16'h0000);
		send_item(dwms_pkg::CMD_PUSH, 16'h8000, 16'hFFFF);
		send_item(dwms_pkg::CMD_SUMMARY, 16'h0, 16'h0);
		send_item(CMD_UNUSED, 16'hFFFF, 16'hFFFF);
		send_item(dwms_pkg::CMD_SUMMARY, 16'h0, 16'h0);
		send_item(dwms_pkg::CMD_CLEAR, 16'hFFFF, 16'hFFFF);
		send_item(dwms_pkg::CMD_SUMMARY, 16'h0, 16'h0);
		for (int i = 0; i < 66; i++)
			send_item(dwms_pkg::CMD_PUSH, (i % 2) ? 16'h7FFF : 16'h8000, 16'hFFFF);
		send_item(dwms_pkg::CMD_SUMMARY, 16'h0, 16'h0);

		// Window lowered below the count: evicts one per push and reads full.
		write_reg(dwms_pkg::CFG_WINDOW_LENGTH, 17'd3);
		write_reg(dwms_pkg::CFG_DECAY_FACTOR, 17'd0);
		send_item(dwms_pkg::CMD_PUSH, 16'h4000, 16'h1111);
		send_item(dwms_pkg::CMD_SUMMARY, 16'h0, 16'h0);

		// Long output stall while items keep coming, then drain fully.
		hold_req = 1'b1;
		for (int i = 0; i < 12; i++)
			send_item(dwms_pkg::CMD_SUMMARY, 16'h0, 16'h0);
		s_tvalid <= 1'b0;
		wait_drained();
		@(posedge clk);

		// Random phases across settings, extremes and special values included.
		write_reg(dwms_pkg::CFG_DECAY_FACTOR, 17'd65536);
		write_reg(dwms_pkg::CFG_WINDOW_LENGTH, 17'd64);
		random_items(170);
		write_reg(dwms_pkg::CFG_WINDOW_LENGTH, 17'd1);
		write_reg(dwms_pkg::CFG_DECAY_FACTOR, 17'd1);
		random_items(120);
		write_reg(dwms_pkg::CFG_WINDOW_LENGTH, 17'd0);
		write_reg(dwms_pkg::CFG_DECAY_FACTOR, 17'h1FFFF);
		random_items(100);
		write_reg(dwms_pkg::CFG_WINDOW_LENGTH, 17'd127);
		write_reg(dwms_pkg::CFG_DECAY_FACTOR, 17'd60000);
		random_items(170);
		write_reg(dwms_pkg::CFG_WINDOW_LENGTH, 17'd65);
		write_reg(dwms_pkg::CFG_DECAY_FACTOR, 17'd32768);
		random_items(120);
		write_reg(dwms_pkg::CFG_WINDOW_LENGTH, 17'($urandom_range(2, 20)));
		write_reg(dwms_pkg::CFG_DECAY_FACTOR, 17'($urandom_range(0, 131071)));
		random_items(120);
		quiet = 1'b1;
		write_reg(dwms_pkg::CFG_WINDOW_LENGTH, 17'd8);
		write_reg(dwms_pkg::CFG_DECAY_FACTOR, 17'd65535);
		random_items(100);
		s_tvalid <= 1'b0;

		wait_drained();
		repeat (300) @(posedge clk);
		if (board.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

FILE: sim.f
hw/rtl/dwms_pkg.sv
hw/rtl/dwms_ram.sv
hw/rtl/dwms_datapath.sv
hw/rtl/dwms_ctrl.sv
hw/rtl/decayed_window_mean_stddev.sv
sim/decayed_window_mean_stddev_tb.sv
